### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while reset is high
`define LPF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication in the next cycle, off while reset is high
`define LPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication in the next cycle, also checked across reset
`define LPF_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/lpf_pkg.sv
// shared constants for the largest prime factor block
package lpf_pkg;

  localparam int SIEVE_LIMIT_DEF = 65536;
  localparam int NUM_W           = 33;
  localparam int FACTOR_W        = 32;
  localparam int STATUS_W        = 2;
  // one quotient bit per step over the whole magnitude
  localparam int DIV_STEPS       = NUM_W;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd2;

endpackage

### hdl/largest_prime_factor.sv
// largest prime factor by trial division over a sieve held in block memory
// synchronous reset clears control and rebuilds the sieve with in_stall high: a fill pass
//   over the bitmap, then each base candidate is read and checked and a prime clears its multiples
// per item: the item is taken, factors of two are stripped, odd candidates are read from the
//   sieve, each sieve prime is tried by a 33-step restoring divider and its check, then a final
//   check and the result; one item at a time, the output register lets the next start meanwhile
module largest_prime_factor
  import lpf_pkg::*;
#(
  parameter int SIEVE_LIMIT = SIEVE_LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [NUM_W-1:0]    number,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [FACTOR_W-1:0]        largest_factor,
  output logic [STATUS_W-1:0]        status
);

  localparam int NW   = $clog2(SIEVE_LIMIT + 1);
  localparam int PW   = NW + 1;
  localparam int SW   = 2 * PW;
  localparam int RW   = NUM_W;
  localparam int CW   = (SW > RW) ? SW : RW;
  localparam int MAPD = SIEVE_LIMIT / 2 + 1;
  localparam int AW   = $clog2(MAPD);
  localparam int DCW  = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_FILL, S_SIV_RD, S_SIV_CHK, S_SIV_CLR, S_IDLE, S_TWO,
    S_ODD_CHK, S_ODD_RD, S_DIV, S_DIV_END, S_FIN, S_DONE
  } state_t;

  state_t          state;
  logic [AW-1:0]   fill_addr;
  logic [PW-1:0]   p;
  logic [SW-1:0]   sq;
  logic [PW-1:0]   j;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   q;
  logic [PW:0]     part;
  logic [DCW-1:0]  div_cnt;
  logic [1:0]      cnt;
  logic [FACTOR_W-1:0] last;
  logic            zero;

  // sieve bitmap, one bit per odd number
  logic            bitmap [MAPD];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic            mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic            mem_rdata;

  logic [RW-1:0]   num_u;
  logic [RW-1:0]   mag;
  logic [PW-1:0]   p_adv;
  logic [SW-1:0]   sq_adv;
  logic [1:0]      cnt_inc;
  logic [PW:0]     trial;
  logic            ge;
  logic            p_over;
  logic            sq_over_rem;

  assign num_u       = RW'(number);
  assign mag         = num_u[RW-1] ? (~num_u + RW'(1)) : num_u;
  assign p_adv       = p + PW'(2);
  assign sq_adv      = sq + SW'({p, 2'b00}) + SW'(4);
  assign cnt_inc     = (cnt == 2'd2) ? cnt : cnt + 2'd1;
  assign trial       = {part[PW-1:0], q[RW-1]};
  assign ge          = trial >= {1'b0, p};
  assign p_over      = p > PW'(SIEVE_LIMIT);
  assign sq_over_rem = CW'(sq) > CW'(rem);
  assign in_stall    = (state != S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_addr;
    mem_wdata = 1'b1;
    mem_re    = 1'b0;
    mem_raddr = p[AW:1];
    case (state)
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_SIV_CLR: begin
        mem_we    = (j <= PW'(SIEVE_LIMIT));
        mem_waddr = j[AW:1];
        mem_wdata = 1'b0;
      end
      S_SIV_RD: begin
        mem_re = 1'b1;
      end
      S_ODD_CHK: begin
        mem_re = !p_over;
      end
      default: begin
      end
    endcase
  end

  // reads follow only finished writes, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= bitmap[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      // the result state sets out_valid itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == AW'(MAPD - 1)) begin
            p     <= PW'(3);
            sq    <= SW'(9);
            state <= S_SIV_RD;
          end
        end
        S_SIV_RD: begin
          if (sq > SW'(SIEVE_LIMIT)) begin
            state <= S_IDLE;
          end else begin
            state <= S_SIV_CHK;
          end
        end
        S_SIV_CHK: begin
          if (mem_rdata) begin
            j     <= sq[PW-1:0];
            state <= S_SIV_CLR;
          end else begin
            p     <= p_adv;
            sq    <= sq_adv;
            state <= S_SIV_RD;
          end
        end
        S_SIV_CLR: begin
          if (j > PW'(SIEVE_LIMIT)) begin
            p     <= p_adv;
            sq    <= sq_adv;
            state <= S_SIV_RD;
          end else begin
            j <= j + PW'({p, 1'b0});
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            rem  <= mag;
            cnt  <= 2'd0;
            last <= '0;
            p    <= PW'(3);
            sq   <= SW'(9);
            zero <= (mag == '0);
            if (mag == '0) begin
              state <= S_DONE;
            end else if (mag >= RW'(4)) begin
              state <= S_TWO;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_TWO: begin
          if (!rem[0]) begin
            rem  <= rem >> 1;
            cnt  <= cnt_inc;
            last <= FACTOR_W'(2);
          end else begin
            state <= S_ODD_CHK;
          end
        end
        S_ODD_CHK: begin
          if (p_over || sq_over_rem) begin
            state <= S_FIN;
          end else begin
            state <= S_ODD_RD;
          end
        end
        S_ODD_RD: begin
          if (mem_rdata) begin
            q       <= rem;
            part    <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            p     <= p_adv;
            sq    <= sq_adv;
            state <= S_ODD_CHK;
          end
        end
        S_DIV: begin
          q       <= {q[RW-2:0], ge};
          part    <= ge ? (trial - {1'b0, p}) : trial;
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(DIV_STEPS - 1)) begin
            state <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          if (part == '0) begin
            // exact: keep the quotient and try the same prime again
            rem     <= q;
            cnt     <= cnt_inc;
            last    <= FACTOR_W'(p);
            part    <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            p     <= p_adv;
            sq    <= sq_adv;
            state <= S_ODD_CHK;
          end
        end
        S_FIN: begin
          if (rem > RW'(1)) begin
            cnt  <= cnt_inc;
            last <= rem[FACTOR_W-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (zero) begin
              status         <= STATUS_ZERO;
              largest_factor <= '0;
            end else if (cnt == 2'd2) begin
              status         <= STATUS_OK;
              largest_factor <= last;
            end else begin
              status         <= STATUS_NONE;
              largest_factor <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/lpf_checker.sv
// port checker for the largest prime factor block, with its bind
`include "assert_macros.svh"

module lpf_checker
  import lpf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [FACTOR_W-1:0] largest_factor,
  input logic [STATUS_W-1:0] status
);

  // a result waiting on the far side holds still
  `LPF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(largest_factor) && $stable(status))

  // no factor goes out with a status that carries no answer
  `LPF_ASSERT_SAME(a_no_answer_zero, out_valid && status != STATUS_OK, largest_factor == '0)

  // a valid answer is a real factor
  `LPF_ASSERT_SAME(a_answer_big, out_valid && status == STATUS_OK, largest_factor > FACTOR_W'(1))

  // only the three defined status codes leave the block
  `LPF_ASSERT_SAME(a_status_code, out_valid, status == STATUS_OK || status == STATUS_NONE || status == STATUS_ZERO)

  // the sieve is rebuilt after reset before any transfer in
  `LPF_ASSERT_ALWAYS(a_busy_after_rst, rst, in_stall)

endmodule

bind largest_prime_factor lpf_checker u_lpf_checker (.*);
